// ===== hw/rtl/nrc_pkg.sv =====
package nrc_pkg;

    localparam int ENTRIES  = 64;
    localparam int KEY_BITS = 64;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int ACT_W    = 2;
    localparam int KEY_W    = 64;
    localparam int NOW_W    = 32;
    localparam int CAP_W    = 7;
    localparam int TTL_W    = 31;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
    localparam logic [TTL_W-1:0] TTL_RESET = '0;

    localparam logic REG_ENTRIES = 1'b0;
    localparam logic REG_TTL     = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_CHECK = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic walk;
    } t_dp_cmd;

    typedef struct packed {
        logic is_check;
        logic walk_end;
    } t_dp_sts;

    // last index in use: capacity clamped to 1..ENTRIES, minus one
    function automatic logic [IDX_W-1:0] cap_last(input logic [CAP_W-1:0] cap);
        int c;
        c = int'(cap);
        if (c < 1) c = 1;
        if (c > ENTRIES) c = ENTRIES;
        return IDX_W'(c - 1);
    endfunction

endpackage

// ===== hw/rtl/nrc_ctrl.sv =====
module nrc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  nrc_pkg::t_dp_sts i_sts,
    output nrc_pkg::t_dp_cmd o_cmd,
    output logic             busy,
    output logic             o_done
);
    import nrc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                n_state = i_sts.is_check ? S_WALK : S_DONE;
            end
            S_WALK: begin
                if (i_sts.walk_end) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        o_cmd.walk = 1'b0;
        busy       = 1'b1;
        o_done     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_DECODE: begin
                o_cmd.exec = 1'b1;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/nrc_dp.sv =====
module nrc_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nrc_pkg::t_dp_cmd            i_cmd,
    output nrc_pkg::t_dp_sts            o_sts,
    input  logic [nrc_pkg::ACT_W-1:0]   i_action,
    input  logic [nrc_pkg::KEY_W-1:0]   i_nonce_key,
    input  logic [nrc_pkg::NOW_W-1:0]   i_now,
    input  logic [nrc_pkg::CAP_W-1:0]   i_entries,
    input  logic [nrc_pkg::TTL_W-1:0]   i_ttl,
    output logic                        o_found
);
    import nrc_pkg::*;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [NOW_W-1:0]    stamp;
    } t_entry;

    t_entry mem [ENTRIES];

    logic [ENTRIES-1:0]  r_valid;
    logic [IDX_W-1:0]    r_wp;
    t_action             r_act;
    logic [KEY_BITS-1:0] r_key;
    logic [NOW_W-1:0]    r_now;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_issue_on;
    logic                r_cmp_vld;
    t_entry              r_rd;
    logic                r_found;

    logic [IDX_W-1:0]    last;
    logic [IDX_W-1:0]    add_idx;
    logic [IDX_W-1:0]    add_next;
    logic [NOW_W-1:0]    age;
    logic                stale;
    logic                cmp_live;
    logic                hit;
    logic                walk_end;
    logic                do_add;
    logic                do_clear;

    always_comb begin
        last     = cap_last(i_entries);
        add_idx  = (r_wp <= last) ? r_wp : '0;
        add_next = (add_idx == last) ? '0 : add_idx + IDX_W'(1);
        age      = r_now - r_rd.stamp;
        stale    = $signed(age) > $signed({1'b0, i_ttl});
        cmp_live = r_cmp_vld & r_valid[r_cmp_idx];
        hit      = cmp_live & ~stale & (r_rd.key == r_key);
        walk_end = r_cmp_vld & (hit | (r_cmp_idx == last));
        do_add   = i_cmd.exec & (r_act == ACT_ADD);
        do_clear = i_cmd.exec & (r_act == ACT_CLEAR);
    end

    assign o_sts.is_check = (r_act == ACT_CHECK);
    assign o_sts.walk_end = walk_end;
    assign o_found        = r_found;

    always_ff @(posedge i_clk) begin
        if (do_add) begin
            mem[add_idx] <= '{key: r_key, stamp: r_now};
        end
        r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= t_action'(i_action);
            r_key <= i_nonce_key[KEY_BITS-1:0];
            r_now <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_wp       <= '0;
            r_idx      <= '0;
            r_cmp_idx  <= '0;
            r_issue_on <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            if (do_clear) begin
                r_valid <= '0;
                r_wp    <= '0;
            end else if (do_add) begin
                r_valid[add_idx] <= |r_key;
                r_wp             <= add_next;
            end else if (i_cmd.walk && cmp_live && stale) begin
                r_valid[r_cmp_idx] <= 1'b0;
            end

            if (i_cmd.load) begin
                r_idx      <= '0;
                r_issue_on <= 1'b1;
                r_cmp_vld  <= 1'b0;
                r_found    <= 1'b0;
            end else if (i_cmd.walk) begin
                r_cmp_vld <= r_issue_on;
                r_cmp_idx <= r_idx;
                if (r_issue_on) begin
                    if (r_idx == last) begin
                        r_issue_on <= 1'b0;
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                if (walk_end) r_found <= hit;
            end
        end
    end

endmodule

// ===== hw/rtl/nonce_replay_cache.sv =====
// Nonce replay cache.
// Items are issued on the command channel: drive i_action, i_nonce_key and
// i_now with start high; the item is taken at the edge where busy is low.
// Each item gives exactly one result: o_done is high for one cycle, with
// o_found valid in that cycle (high only for a check that hit a live entry).
// Add, clear and the unused action: the result follows the decode state.
// Check: entries are read one per cycle from the key/stamp memory and
// compared in the cycle after, so the walk covers at most cap entries
// (cap = entries in use, clamped to 1..64) and ends sooner on a hit.
// busy drops in the cycle after o_done; one item is in flight at a time.
// The receiver cannot stall; results are not held.
// Configuration over the APB port: entries_in_use at 0x0, ttl_limit at 0x4;
// write only while idle.
// Reset (synchronous, active low) empties the table, zeroes the write
// pointer and restores entries_in_use to 64 and ttl_limit to 0.
module nonce_replay_cache (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [nrc_pkg::ACT_W-1:0]    i_action,
    input  logic [nrc_pkg::KEY_W-1:0]    i_nonce_key,
    input  logic [nrc_pkg::NOW_W-1:0]    i_now,
    output logic                         o_done,
    output logic                         o_found,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [nrc_pkg::DATA_W-1:0]   pwdata,
    output logic [nrc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import nrc_pkg::*;

    logic [CAP_W-1:0] r_entries;
    logic [TTL_W-1:0] r_ttl;
    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;
    logic             dp_found;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries <= CAP_RESET;
            r_ttl     <= TTL_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_ENTRIES: r_entries <= pwdata[CAP_W-1:0];
                REG_TTL:     r_ttl     <= pwdata[TTL_W-1:0];
                default:     r_ttl     <= r_ttl;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ENTRIES: prdata = DATA_W'(r_entries);
            REG_TTL:     prdata = DATA_W'(r_ttl);
            default:     prdata = '0;
        endcase
    end

    nrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    nrc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_action    (i_action),
        .i_nonce_key (i_nonce_key),
        .i_now       (i_now),
        .i_entries   (r_entries),
        .i_ttl       (r_ttl),
        .o_found     (dp_found)
    );

    assign o_found = dp_found & o_done;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("block not idle after result beat");

    a_found_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> (o_done && dp_sts.is_check))
        else $error("found outside a check result");

endmodule
